// File: design/eatrm_pkg.sv
package eatrm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int CORDIC_STEPS   = 28;
  localparam int CW             = 34;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;
  localparam int OUT_W          = 16;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic signed [CW-1:0] COEF_ONE    = CW'(1) <<< COEF_FRAC_BITS;

  typedef logic [ANGLE_BITS-1:0]    angle_t;
  typedef logic signed [OUT_W-1:0]  entry_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    angle_t yaw_angle;
    angle_t pitch_angle;
    angle_t roll_angle;
  } angles_t;

  typedef struct packed {
    entry_t r00; entry_t r01; entry_t r02;
    entry_t r10; entry_t r11; entry_t r12;
    entry_t r20; entry_t r21; entry_t r22;
  } matrix_t;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] t;
    case (i)
      0: t = CW'(32'h20000000);  1: t = CW'(32'h12E4051E);
      2: t = CW'(32'h09FB385B);  3: t = CW'(32'h051111D4);
      4: t = CW'(32'h028B0D43);  5: t = CW'(32'h0145D7E1);
      6: t = CW'(32'h00A2F61E);  7: t = CW'(32'h00517C55);
      8: t = CW'(32'h0028BE53);  9: t = CW'(32'h00145F2F);
      10: t = CW'(32'h000A2F98); 11: t = CW'(32'h000517CC);
      12: t = CW'(32'h00028BE6); 13: t = CW'(32'h000145F3);
      14: t = CW'(32'h0000A2FA); 15: t = CW'(32'h0000517D);
      16: t = CW'(32'h000028BE); 17: t = CW'(32'h0000145F);
      18: t = CW'(32'h00000A30); 19: t = CW'(32'h00000518);
      20: t = CW'(32'h0000028C); 21: t = CW'(32'h00000146);
      22: t = CW'(32'h000000A3); 23: t = CW'(32'h00000051);
      24: t = CW'(32'h00000029); 25: t = CW'(32'h00000014);
      26: t = CW'(32'h0000000A); 27: t = CW'(32'h00000005);
      default: t = '0;
    endcase
    return t;
  endfunction

  // Clamp a wide value to plus or minus one in coefficient format.
  function automatic coef_t clamp_unit(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > COEF_ONE) r = COEF_ONE;
    else if (v < -COEF_ONE) r = -COEF_ONE;
    else r = v;
    return coef_t'(r);
  endfunction

  // Rounded product of two coefficients, half rounded up.
  function automatic logic signed [COEF_W+1:0] mulq(input coef_t a, input coef_t b);
    logic signed [2*COEF_W-1:0] p;
    p = a * b + ((2*COEF_W)'(1) <<< (COEF_FRAC_BITS - 1));
    return (COEF_W+2)'(p >>> COEF_FRAC_BITS);
  endfunction

  function automatic entry_t put(input logic signed [COEF_W+2:0] v);
    return entry_t'(clamp_unit(CW'(v)));
  endfunction

endpackage

// File: design/eatrm_if.sv
interface eatrm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/euler_angles_to_rotation_matrix.sv
// ZYX Euler angles to rotation matrix, fully pipelined.
// The in channel carries yaw, pitch and roll as binary angles (65536 is one
// turn); the out channel carries the nine Q1.14 entries of
// Rz(yaw)*Ry(pitch)*Rx(roll), each clamped to plus or minus 16384.
// A transfer happens on a clock edge with valid and ready both high.
// Sine and cosine come from three 28-step CORDICs: a seed stage, then one
// iteration per stage, followed by a rounding and quadrant stage, a product
// stage and a final stage that forms the triple products and the sums.
// Throughput is one item per cycle while the receiver does not stall.
// The whole pipeline advances together: when the receiver stalls, every
// stage holds, in.ready drops and nothing is lost or repeated.  The last
// stage is the output register.
// Reset clears all valid bits; payload registers are not reset.
module euler_angles_to_rotation_matrix (
  input  logic  clk_i,
  input  logic  rst_ni,
  eatrm_if.sink   in_ch,
  eatrm_if.source out_ch
);
  localparam int S = eatrm_pkg::CORDIC_STEPS;
  localparam int CW = eatrm_pkg::CW;
  localparam int CWD = eatrm_pkg::COEF_W;
  localparam int NS = S + 4;

  typedef logic signed [CW-1:0] w_t;
  typedef struct packed {
    w_t x; w_t y; w_t z; logic [1:0] q;
  } cs_t;

  logic      adv;
  logic [NS-1:0] vld_q;
  cs_t       cs_q [3][S+1];
  eatrm_pkg::coef_t c_q [3], s_q [3];
  logic signed [CWD+1:0] cysp_q, sysp_q, p00_q, p10_q, p21_q, p22_q;
  logic signed [CWD+1:0] sycr_q, sysr_q, cycr_q, cysr_q;
  eatrm_pkg::coef_t sr2_q, cr2_q, sp2_q;
  eatrm_pkg::matrix_t out_q;

  assign adv = !vld_q[NS-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld_q[NS-1];
  assign out_ch.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_ch.valid};
    end
  end

  function automatic cs_t seed(input eatrm_pkg::angle_t a);
    cs_t r;
    logic [31:0] t;
    t = 32'(a) << (32 - eatrm_pkg::ANGLE_BITS);
    r.q = t[31:30];
    r.z = CW'({2'b00, t[29:0]});
    r.x = eatrm_pkg::CORDIC_GAIN;
    r.y = '0;
    return r;
  endfunction

  function automatic cs_t iter(input cs_t v, input int i);
    cs_t r;
    r = v;
    if (!v.z[CW-1]) begin
      r.x = v.x - (v.y >>> i); r.y = v.y + (v.x >>> i);
      r.z = v.z - eatrm_pkg::atan_turn(i);
    end else begin
      r.x = v.x + (v.y >>> i); r.y = v.y - (v.x >>> i);
      r.z = v.z + eatrm_pkg::atan_turn(i);
    end
    return r;
  endfunction

  function automatic eatrm_pkg::coef_t to_coef(input w_t v);
    localparam int SH = 30 - eatrm_pkg::COEF_FRAC_BITS;
    return eatrm_pkg::clamp_unit((v + (w_t'(1) <<< (SH - 1))) >>> SH);
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cs_q[0][0] <= seed(in_ch.data.yaw_angle);
      cs_q[1][0] <= seed(in_ch.data.pitch_angle);
      cs_q[2][0] <= seed(in_ch.data.roll_angle);
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < S; i++) cs_q[k][i+1] <= iter(cs_q[k][i], i);
      end
      // Quadrant fold after the final iteration.
      for (int k = 0; k < 3; k++) begin
        case (cs_q[k][S].q)
          2'd0: begin
            c_q[k] <= to_coef(cs_q[k][S].x);  s_q[k] <= to_coef(cs_q[k][S].y);
          end
          2'd1: begin
            c_q[k] <= -to_coef(cs_q[k][S].y); s_q[k] <= to_coef(cs_q[k][S].x);
          end
          2'd2: begin
            c_q[k] <= -to_coef(cs_q[k][S].x); s_q[k] <= -to_coef(cs_q[k][S].y);
          end
          default: begin
            c_q[k] <= to_coef(cs_q[k][S].y);  s_q[k] <= -to_coef(cs_q[k][S].x);
          end
        endcase
      end
      cysp_q <= eatrm_pkg::mulq(c_q[0], s_q[1]);
      sysp_q <= eatrm_pkg::mulq(s_q[0], s_q[1]);
      p00_q  <= eatrm_pkg::mulq(c_q[0], c_q[1]);
      p10_q  <= eatrm_pkg::mulq(s_q[0], c_q[1]);
      p21_q  <= eatrm_pkg::mulq(c_q[1], s_q[2]);
      p22_q  <= eatrm_pkg::mulq(c_q[1], c_q[2]);
      sycr_q <= eatrm_pkg::mulq(s_q[0], c_q[2]);
      sysr_q <= eatrm_pkg::mulq(s_q[0], s_q[2]);
      cycr_q <= eatrm_pkg::mulq(c_q[0], c_q[2]);
      cysr_q <= eatrm_pkg::mulq(c_q[0], s_q[2]);
      sr2_q <= s_q[2]; cr2_q <= c_q[2]; sp2_q <= s_q[1];
      // cysp and sysp never exceed one, so they fit coef_t.
      out_q.r00 <= eatrm_pkg::put((CWD+3)'(p00_q));
      out_q.r01 <= eatrm_pkg::put((CWD+3)'(eatrm_pkg::mulq(CWD'(cysp_q), sr2_q))
                                  - (CWD+3)'(sycr_q));
      out_q.r02 <= eatrm_pkg::put((CWD+3)'(eatrm_pkg::mulq(CWD'(cysp_q), cr2_q))
                                  + (CWD+3)'(sysr_q));
      out_q.r10 <= eatrm_pkg::put((CWD+3)'(p10_q));
      out_q.r11 <= eatrm_pkg::put((CWD+3)'(eatrm_pkg::mulq(CWD'(sysp_q), sr2_q))
                                  + (CWD+3)'(cycr_q));
      out_q.r12 <= eatrm_pkg::put((CWD+3)'(eatrm_pkg::mulq(CWD'(sysp_q), cr2_q))
                                  - (CWD+3)'(cysr_q));
      out_q.r20 <= eatrm_pkg::put(-(CWD+3)'(sp2_q));
      out_q.r21 <= eatrm_pkg::put((CWD+3)'(p21_q));
      out_q.r22 <= eatrm_pkg::put((CWD+3)'(p22_q));
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("pipeline stalled with empty output");
  a_r20: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.data.r20 <= 16'sd16384 && out_ch.data.r20 >= -16'sd16384)
    else $error("entry out of range");
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_RANDOM = 850;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  eatrm_if #(.T(eatrm_pkg::angles_t)) in_ch ();
  eatrm_if #(.T(eatrm_pkg::matrix_t)) out_ch ();

  euler_angles_to_rotation_matrix u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  eatrm_pkg::angles_t pending_angles[$];
  eatrm_pkg::matrix_t expected_matrices[$];
  int send_idle_pct = 22;
  int recv_idle_pct = 45;
  bit hold_send = 1'b0;
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Floor shift of a signed value.
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp_one(longint v);
    longint one;
    one = longint'(1) << eatrm_pkg::COEF_FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint round_coef(longint q30);
    return clamp_one(floor_shift(q30 + (longint'(1) << 15), 16));
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_shift(a * b + (longint'(1) << (eatrm_pkg::COEF_FRAC_BITS - 1)),
                       eatrm_pkg::COEF_FRAC_BITS);
  endfunction

  function automatic eatrm_pkg::entry_t sat_entry(longint v);
    return eatrm_pkg::entry_t'(clamp_one(v));
  endfunction

  function automatic void cordic_sincos(input eatrm_pkg::angle_t ang, output longint c,
                                        output longint s);
    longint steps[28];
    longint x, y, z, dx, dy, cx, sy;
    logic [31:0] a;
    logic [1:0] quad;
    steps = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005};
    a = {ang, 16'h0};
    quad = a[31:30];
    z = longint'(a[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= steps[i];
      end else begin
        x += dx; y -= dy; z += steps[i];
      end
    end
    cx = round_coef(x);
    sy = round_coef(y);
    case (quad)
      2'd0: begin c = cx; s = sy; end
      2'd1: begin c = -sy; s = cx; end
      2'd2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
  endfunction

  function automatic eatrm_pkg::matrix_t rotation_of(eatrm_pkg::angles_t ang);
    longint cy, sy, cp, sp, cr, sr, cysp, sysp;
    eatrm_pkg::matrix_t m;
    cordic_sincos(ang.yaw_angle, cy, sy);
    cordic_sincos(ang.pitch_angle, cp, sp);
    cordic_sincos(ang.roll_angle, cr, sr);
    cysp = qmul(cy, sp);
    sysp = qmul(sy, sp);
    m.r00 = sat_entry(qmul(cy, cp));
    m.r01 = sat_entry(qmul(cysp, sr) - qmul(sy, cr));
    m.r02 = sat_entry(qmul(cysp, cr) + qmul(sy, sr));
    m.r10 = sat_entry(qmul(sy, cp));
    m.r11 = sat_entry(qmul(sysp, sr) + qmul(cy, cr));
    m.r12 = sat_entry(qmul(sysp, cr) - qmul(cy, sr));
    m.r20 = sat_entry(-sp);
    m.r21 = sat_entry(qmul(cp, sr));
    m.r22 = sat_entry(qmul(cp, cr));
    return m;
  endfunction

  function automatic eatrm_pkg::angle_t rand_angle();
    case ($urandom_range(0, 5))
      0: return eatrm_pkg::angle_t'($urandom_range(0, 3)) << 14;
      1: return eatrm_pkg::angle_t'((eatrm_pkg::angle_t'($urandom_range(0, 3)) << 14)
                                    + eatrm_pkg::angle_t'($urandom_range(0, 8))
                                    - eatrm_pkg::angle_t'(4));
      default: return eatrm_pkg::angle_t'($urandom());
    endcase
  endfunction

  function automatic void check_entry(string name, eatrm_pkg::entry_t exp_v,
                                      eatrm_pkg::entry_t got_v);
    if (got_v !== exp_v) begin
      $error("%s exp %0d got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Driver: a transfer pops the queue; valid only changes when not stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_matrices.push_back(rotation_of(in_ch.data));
        void'(pending_angles.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_angles.size() > 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_angles[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    eatrm_pkg::matrix_t exp_m, got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles <= 0;
        got = out_ch.data;
        if (expected_matrices.size() == 0) begin
          $error("unexpected result transfer %h", got);
          errors++;
        end else begin
          exp_m = expected_matrices.pop_front();
          check_entry("r00", exp_m.r00, got.r00);
          check_entry("r01", exp_m.r01, got.r01);
          check_entry("r02", exp_m.r02, got.r02);
          check_entry("r10", exp_m.r10, got.r10);
          check_entry("r11", exp_m.r11, got.r11);
          check_entry("r12", exp_m.r12, got.r12);
          check_entry("r20", exp_m.r20, got.r20);
          check_entry("r21", exp_m.r21, got.r21);
          check_entry("r22", exp_m.r22, got.r22);
        end
      end else if (in_ch.valid && in_ch.ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_angles.size() > 0 || in_ch.valid || expected_matrices.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    eatrm_pkg::angle_t specials[8];
    eatrm_pkg::angles_t a;
    specials = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001, 16'h2000,
                 16'h3FFF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: quadrant boundaries and extremes on each axis.
    for (int i = 0; i < 8; i++) begin
      a = '{specials[i], specials[(i + 3) % 8], specials[(i + 5) % 8]};
      pending_angles.push_back(a);
    end
    pending_angles.push_back(eatrm_pkg::angles_t'{16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_angles.push_back(eatrm_pkg::angles_t'{16'h5555, 16'hAAAA, 16'h5555});
    pending_angles.push_back(eatrm_pkg::angles_t'{16'hAAAA, 16'h5555, 16'hAAAA});
    pending_angles.push_back(eatrm_pkg::angles_t'{16'h4000, 16'h4000, 16'h4000});
    pending_angles.push_back(eatrm_pkg::angles_t'{16'hC000, 16'hC000, 16'hC000});
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 45; recv_idle_pct = 22; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int n = 0; n < NUM_RANDOM / 3; n++) begin
        a = '{rand_angle(), rand_angle(), rand_angle()};
        pending_angles.push_back(a);
      end
      if (phase == 0) begin
        // Pause the sender mid-stream until every expected result is back.
        repeat (60) @(posedge clk_i);
        hold_send = 1'b1;
        while (in_ch.valid || expected_matrices.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      wait_drained();
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && expected_matrices.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
